FILE: rtl/double_ended_queue_indexed_assert.svh
// Assertion macros for the indexed double-ended queue.
`ifndef DOUBLE_ENDED_QUEUE_INDEXED_ASSERT_SVH
`define DOUBLE_ENDED_QUEUE_INDEXED_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define DEQ_IDX_ASSERT_NOW(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("deque check failed");

// Next-cycle implication, sampled on clock, off during reset.
`define DEQ_IDX_ASSERT_NEXT(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("deque check failed");

`endif

FILE: rtl/deq_idx_pkg.sv
// Shared types and constants for the indexed double-ended queue.
package deq_idx_pkg;

   localparam int DEPTH_DEFAULT      = 16;
   localparam int DATA_WIDTH_DEFAULT = 32;

   typedef enum logic [2:0] {
      OP_PUSH_BACK  = 3'd0,
      OP_PUSH_FRONT = 3'd1,
      OP_POP_BACK   = 3'd2,
      OP_POP_FRONT  = 3'd3,
      OP_READ       = 3'd4,
      OP_CLEAR      = 3'd5
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

endpackage

FILE: rtl/deq_idx_ram.sv
// Generic single-write, single-read RAM with registered read data.
module deq_idx_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/double_ended_queue_indexed.sv
// Indexed double-ended queue: ring of slots in RAM with head and count registers.
// The result strobe is registered and comes in the cycle after the transfer is taken.
// Throughput: one transfer per cycle once busy is low; head and count are registers,
// and the slot RAMs (one copy per read port: index, front, back) have registered reads.
// Reset clears head and count; busy stays high for the first cycle after reset.
// The receiver cannot stall: each result is shown for exactly one cycle.
`include "double_ended_queue_indexed_assert.svh"

module double_ended_queue_indexed
   import deq_idx_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEFAULT,
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_op,
   input  logic [31:0] req_value,
   input  logic [3:0]  req_index,
   output logic        rsp_strobe,
   output logic [31:0] rsp_read_data,
   output logic [31:0] rsp_front_value,
   output logic [31:0] rsp_back_value,
   output logic [4:0]  rsp_size,
   output logic        rsp_is_empty,
   output logic [1:0]  rsp_status
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = (AW + 1 > 5) ? AW + 1 : 5;

   function automatic logic [AW-1:0] wrap(input logic [SW-1:0] s);
      logic [SW-1:0] r;
      if (s >= SW'(DEPTH)) begin
         r = s - SW'(DEPTH);
      end else begin
         r = s;
      end
      return r[AW-1:0];
   endfunction

   logic                  busy_ff;
   logic                  strobe_ff;
   logic [AW-1:0]         head_ff, head_in;
   logic [CW-1:0]         count_ff, count_in;

   logic                  accept;
   op_type                op;
   status_type            status;
   logic                  full, empty;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic                  rd_ok;
   logic [AW-1:0]         idx_addr, front_addr, back_addr;

   logic                  rd_ok_ff;
   logic                  fwd_front_ff, fwd_back_ff;
   logic                  empty_ff;
   logic [DATA_WIDTH-1:0] wr_data_ff;
   status_type            status_ff;
   logic [4:0]            size_ff;

   logic [DATA_WIDTH-1:0] idx_q, front_q, back_q;

   assign accept  = start & ~busy;
   assign op      = op_type'(req_op);
   assign full    = (count_ff == CW'(DEPTH));
   assign empty   = (count_ff == '0);
   assign wr_data = DATA_WIDTH'(req_value);

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      status   = ST_OK;
      wr_en    = 1'b0;
      wr_addr  = wrap(SW'(head_ff) + SW'(count_ff));
      rd_ok    = 1'b0;
      unique case (op)
         OP_PUSH_BACK: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + CW'(1);
            end
         end
         OP_PUSH_FRONT: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               head_in  = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - AW'(1);
               wr_addr  = head_in;
               wr_en    = 1'b1;
               count_in = count_ff + CW'(1);
            end
         end
         OP_POP_BACK: begin
            if (empty) begin
               status = ST_EMPTY;
            end else begin
               count_in = count_ff - CW'(1);
            end
         end
         OP_POP_FRONT: begin
            if (empty) begin
               status = ST_EMPTY;
            end else begin
               head_in  = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + AW'(1);
               count_in = count_ff - CW'(1);
            end
         end
         OP_READ: begin
            if (SW'(req_index) >= SW'(count_ff)) begin
               status = ST_RANGE;
            end else begin
               rd_ok = 1'b1;
            end
         end
         OP_CLEAR: begin
            head_in  = '0;
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   assign idx_addr   = wrap(SW'(head_ff) + SW'(req_index));
   assign front_addr = head_in;
   assign back_addr  = (count_in == '0) ? head_in
                                        : wrap(SW'(head_in) + SW'(count_in) - SW'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b1;
         strobe_ff <= 1'b0;
         head_ff   <= '0;
         count_ff  <= '0;
      end else begin
         busy_ff   <= 1'b0;
         strobe_ff <= accept;
         if (accept) begin
            head_ff  <= head_in;
            count_ff <= count_in;
         end
      end
   end

   // write-through bypass: RAM read returns old data on a same-address write
   always_ff @(posedge clock) begin
      rd_ok_ff     <= rd_ok;
      fwd_front_ff <= wr_en && (wr_addr == front_addr);
      fwd_back_ff  <= wr_en && (wr_addr == back_addr);
      wr_data_ff   <= wr_data;
      status_ff    <= status;
      empty_ff     <= (count_in == '0);
      size_ff      <= 5'(count_in);
   end

   deq_idx_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_ram_idx (
      .clock   (clock),
      .wr_en   (accept & wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_addr),
      .rd_data (idx_q)
   );

   deq_idx_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_ram_front (
      .clock   (clock),
      .wr_en   (accept & wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (front_addr),
      .rd_data (front_q)
   );

   deq_idx_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_ram_back (
      .clock   (clock),
      .wr_en   (accept & wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (back_addr),
      .rd_data (back_q)
   );

   assign busy            = busy_ff;
   assign rsp_strobe      = strobe_ff;
   assign rsp_read_data   = rd_ok_ff ? 32'(idx_q) : '0;
   assign rsp_front_value = empty_ff ? '0 : (fwd_front_ff ? 32'(wr_data_ff) : 32'(front_q));
   assign rsp_back_value  = empty_ff ? '0 : (fwd_back_ff ? 32'(wr_data_ff) : 32'(back_q));
   assign rsp_size        = size_ff;
   assign rsp_is_empty    = empty_ff;
   assign rsp_status      = status_ff;

   `DEQ_IDX_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= CW'(DEPTH))
   `DEQ_IDX_ASSERT_NEXT(a_result_follows, accept, rsp_strobe)
   `DEQ_IDX_ASSERT_NOW(a_empty_matches, rsp_strobe, rsp_is_empty == (count_ff == '0))
   `DEQ_IDX_ASSERT_NEXT(a_full_push_held,
      accept && full && (op == OP_PUSH_BACK || op == OP_PUSH_FRONT),
      $stable(count_ff) && rsp_status == ST_FULL)
   `DEQ_IDX_ASSERT_NOW(a_empty_pop, rsp_strobe && rsp_status == ST_EMPTY, rsp_is_empty)

endmodule

FILE: test/deq_idx_checker.sv
// Scoreboard for the indexed deque: tracks the queue contents and checks every result.
`timescale 1ns / 1ps

module deq_idx_checker
   import deq_idx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [2:0]  req_op,
   input  logic [31:0] req_value,
   input  logic [3:0]  req_index,
   input  logic        rsp_strobe,
   input  logic [31:0] rsp_read_data,
   input  logic [31:0] rsp_front_value,
   input  logic [31:0] rsp_back_value,
   input  logic [4:0]  rsp_size,
   input  logic        rsp_is_empty,
   input  logic [1:0]  rsp_status,
   output int          fail_count,
   output int          pending,
   output int          checked,
   output int          full_hits,
   output int          empty_hits,
   output int          range_hits
);

   localparam int DEPTH = DEPTH_DEFAULT;

   typedef struct packed {
      logic [31:0] read_data;
      logic [31:0] front_value;
      logic [31:0] back_value;
      logic [4:0]  size;
      logic        is_empty;
      status_type  status;
   } deq_result_type;

   logic [31:0] ring [0:DEPTH-1];
   logic [3:0]  head;
   logic [4:0]  count;
   deq_result_type expected_q [$];

   initial begin
      foreach (ring[i]) ring[i] = '0;
      head       = '0;
      count      = '0;
      fail_count = 0;
      pending    = 0;
      checked    = 0;
      full_hits  = 0;
      empty_hits = 0;
      range_hits = 0;
   end

   function automatic deq_result_type apply_op(logic [2:0] op, logic [31:0] value,
                                               logic [3:0] index);
      deq_result_type res;
      logic [3:0]     last;
      res = '0;
      res.status = ST_OK;
      case (op)
         OP_PUSH_BACK: begin
            if (count == DEPTH) begin
               res.status = ST_FULL;
            end else begin
               ring[head + count[3:0]] = value;
               count = count + 5'd1;
            end
         end
         OP_PUSH_FRONT: begin
            if (count == DEPTH) begin
               res.status = ST_FULL;
            end else begin
               head = head - 4'd1;
               ring[head] = value;
               count = count + 5'd1;
            end
         end
         OP_POP_BACK: begin
            if (count == 0) res.status = ST_EMPTY;
            else count = count - 5'd1;
         end
         OP_POP_FRONT: begin
            if (count == 0) begin
               res.status = ST_EMPTY;
            end else begin
               head = head + 4'd1;
               count = count - 5'd1;
            end
         end
         OP_READ: begin
            if ({1'b0, index} >= count) res.status = ST_RANGE;
            else res.read_data = ring[head + index];
         end
         OP_CLEAR: begin
            count = '0;
            head = '0;
         end
         default: ;
      endcase
      last = head + count[3:0] - 4'd1;
      res.front_value = (count != 0) ? ring[head] : '0;
      res.back_value  = (count != 0) ? ring[last] : '0;
      res.size        = count;
      res.is_empty    = (count == 0);
      return res;
   endfunction

   always @(posedge clock) begin
      deq_result_type want;
      deq_result_type got;
      if (!reset) begin
         if (start && !busy)
            expected_q.insert(expected_q.size(), apply_op(req_op, req_value, req_index));
         if (rsp_strobe) begin
            got = {rsp_read_data, rsp_front_value, rsp_back_value, rsp_size, rsp_is_empty,
                   status_type'(rsp_status)};
            if (expected_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("[%0t] unexpected result transfer: status %0d size %0d",
                           $realtime, rsp_status, rsp_size);
            end else begin
               want = expected_q[0];
               expected_q.delete(0);
               checked++;
               case (want.status)
                  ST_FULL:  full_hits++;
                  ST_EMPTY: empty_hits++;
                  ST_RANGE: range_hits++;
                  default: ;
               endcase
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("[%0t] mismatch on result %0d", $realtime, checked);
                     $display("   read_data   exp %h got %h", want.read_data, got.read_data);
                     $display("   front_value exp %h got %h", want.front_value,
                              got.front_value);
                     $display("   back_value  exp %h got %h", want.back_value,
                              got.back_value);
                     $display("   size        exp %0d got %0d", want.size, got.size);
                     $display("   is_empty    exp %0d got %0d", want.is_empty, got.is_empty);
                     $display("   status      exp %0d got %0d", want.status, got.status);
                  end
               end
            end
         end
      end
      pending <= expected_q.size();
   end

endmodule

FILE: test/tb_top.sv
// Testbench top for the indexed deque: reset, directed and random stimulus, verdict.
`timescale 1ns / 1ps

module tb_top;
   import deq_idx_pkg::*;

   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;
   localparam int MODE_FILL  = 0;
   localparam int MODE_DRAIN = 1;
   localparam int MODE_MIXED = 2;
   localparam int RANDOM_ITEMS = 1130;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [2:0]  req_op;
   logic [31:0] req_value;
   logic [3:0]  req_index;
   logic        rsp_strobe;
   logic [31:0] rsp_read_data;
   logic [31:0] rsp_front_value;
   logic [31:0] rsp_back_value;
   logic [4:0]  rsp_size;
   logic        rsp_is_empty;
   logic [1:0]  rsp_status;

   int  fail_count;
   int  pending;
   int  checked;
   int  full_hits;
   int  empty_hits;
   int  range_hits;
   int  sent;
   bit  gaps_on;

   double_ended_queue_indexed u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_value       (req_value),
      .req_index       (req_index),
      .rsp_strobe      (rsp_strobe),
      .rsp_read_data   (rsp_read_data),
      .rsp_front_value (rsp_front_value),
      .rsp_back_value  (rsp_back_value),
      .rsp_size        (rsp_size),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_status      (rsp_status)
   );

   deq_idx_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_value       (req_value),
      .req_index       (req_index),
      .rsp_strobe      (rsp_strobe),
      .rsp_read_data   (rsp_read_data),
      .rsp_front_value (rsp_front_value),
      .rsp_back_value  (rsp_back_value),
      .rsp_size        (rsp_size),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_status      (rsp_status),
      .fail_count      (fail_count),
      .pending         (pending),
      .checked         (checked),
      .full_hits       (full_hits),
      .empty_hits      (empty_hits),
      .range_hits      (range_hits)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #5ms;
      $display("RESULT: ERROR");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!gaps_on || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   function automatic logic [31:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return 32'h0000_0000;
      if (r < 16) return 32'hFFFF_FFFF;
      return $urandom();
   endfunction

   function automatic logic [2:0] pick_op(int mode);
      int r;
      r = $urandom_range(0, 99);
      case (mode)
         MODE_FILL: begin
            if (r < 40) return OP_PUSH_BACK;
            if (r < 75) return OP_PUSH_FRONT;
            if (r < 88) return OP_READ;
            if (r < 94) return OP_POP_FRONT;
            return OP_POP_BACK;
         end
         MODE_DRAIN: begin
            if (r < 35) return OP_POP_BACK;
            if (r < 70) return OP_POP_FRONT;
            if (r < 85) return OP_READ;
            if (r < 92) return OP_PUSH_BACK;
            return OP_PUSH_FRONT;
         end
         default: begin
            if (r < 18) return OP_PUSH_BACK;
            if (r < 36) return OP_PUSH_FRONT;
            if (r < 52) return OP_POP_BACK;
            if (r < 68) return OP_POP_FRONT;
            if (r < 92) return OP_READ;
            if (r < 95) return OP_CLEAR;
            if (r < 97) return OP_SPARE_LO;
            return OP_SPARE_HI;
         end
      endcase
   endfunction

   // One transfer: hold the request until busy is low at a clock edge, then maybe idle.
   task automatic send(logic [2:0] op, logic [31:0] value, logic [3:0] index);
      int gap;
      start     <= 1'b1;
      req_op    <= op;
      req_value <= value;
      req_index <= index;
      do @(posedge clock); while (busy);
      sent++;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   initial begin
      int mode;
      int phase_left;
      int waited;
      int leftover;
      reset     = 1'b1;
      start     = 1'b0;
      req_op    = OP_PUSH_BACK;
      req_value = '0;
      req_index = '0;
      sent      = 0;
      gaps_on   = 1'b1;
      leftover  = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send(OP_CLEAR, 32'h0, 4'd0);
      send(OP_POP_BACK, 32'h0, 4'd0);
      send(OP_POP_FRONT, 32'h0, 4'd0);
      send(OP_READ, 32'h0, 4'd0);
      send(OP_SPARE_LO, 32'hFFFF_FFFF, 4'hF);
      send(OP_SPARE_HI, 32'h0, 4'h0);
      send(OP_PUSH_BACK, 32'h0000_0000, 4'h0);
      send(OP_PUSH_BACK, 32'hFFFF_FFFF, 4'hF);
      send(OP_PUSH_FRONT, 32'hAAAA_5555, 4'h0);
      send(OP_PUSH_FRONT, 32'h5555_AAAA, 4'h0);
      send(OP_READ, 32'h0, 4'd0);
      send(OP_READ, 32'h0, 4'd3);
      send(OP_READ, 32'h0, 4'd4);
      send(OP_READ, 32'h0, 4'd15);
      send(OP_POP_FRONT, 32'h0, 4'd0);
      send(OP_POP_BACK, 32'h0, 4'd0);
      send(OP_SPARE_HI, 32'h0, 4'd0);
      send(OP_CLEAR, 32'h0, 4'd0);
      send(OP_READ, 32'h0, 4'd0);

      phase_left = 0;
      mode = MODE_FILL;
      repeat (RANDOM_ITEMS) begin
         if (phase_left == 0) begin
            mode       = $urandom_range(MODE_FILL, MODE_MIXED);
            phase_left = $urandom_range(30, 60);
            gaps_on    = ($urandom_range(0, 3) != 0);
         end
         phase_left--;
         send(pick_op(mode), pick_value(), 4'($urandom_range(0, 15)));
      end
      start <= 1'b0;

      waited = 0;
      while (pending != 0 && waited < 1000) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
      leftover = pending;
      if (leftover != 0) $display("%0d expected results never arrived", leftover);

      $display("Sent %0d transfers, checked %0d results.", sent, checked);
      $display("Hit %0d full pushes, %0d empty pops, %0d out-of-range reads.",
               full_hits, empty_hits, range_hits);
      if (fail_count == 0 && leftover == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
